### rtl/core/dsps_pkg.sv
// dsps_pkg: shared types, coil table and per-motor step function
// for the dual stepper phase sequencer; no dependencies
`default_nettype none

package dsps_pkg;

	typedef struct packed {
		logic [2:0] held_speed;
		logic [2:0] countdown;
		logic [1:0] phase;
	} motor_t;

	localparam logic [3:0] COIL_P0 = 4'b0101;
	localparam logic [3:0] COIL_P1 = 4'b1001;
	localparam logic [3:0] COIL_P2 = 4'b1010;
	localparam logic [3:0] COIL_P3 = 4'b0110;

	localparam logic [2:0] TEST_SPEED = 3'd1;

	function automatic logic [3:0] coil_of(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0:    pat = COIL_P0;
			2'd1:    pat = COIL_P1;
			2'd2:    pat = COIL_P2;
			default: pat = COIL_P3;
		endcase
		return pat;
	endfunction

	function automatic motor_t motor_step(input motor_t m, input logic [2:0] speed,
		input logic up);
		motor_t n;
		n = m;
		if (m.held_speed != speed) begin
			n.held_speed = speed;
			n.countdown  = speed;
		end else if (m.countdown != 3'd0) begin
			n.countdown = m.countdown - 3'd1;
		end else begin
			n.countdown = m.held_speed;
			n.phase     = up ? m.phase + 2'd1 : m.phase - 2'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/core/dual_stepper_phase_sequencer_core.sv
// a transaction passes the input register and then the result register
// throughput: one transaction per cycle when not stalled; motor state updates as an item
// leaves the input register; a stalled result holds both stages; the input side takes a new
// item whenever the input register is empty or moves on in the same cycle
// reset: asynchronous, active low; clears valids, tick phase and both motor states
// depends on dsps_pkg
`default_nettype none

module dual_stepper_phase_sequencer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [11:0] command_word,
	input  wire logic        test_mode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       coil_a,
	output logic [3:0]       coil_b
);

	logic             valid_s1;
	logic [11:0]      cmd_s1;
	logic             test_s1;
	logic             tick_q;
	dsps_pkg::motor_t mot_a_q;
	dsps_pkg::motor_t mot_b_q;
	logic             out_valid_q;
	logic [3:0]       coil_a_q;
	logic [3:0]       coil_b_q;

	logic             advance;
	logic             take;
	logic             en_a;
	logic             en_b;
	logic             up_a;
	logic             up_b;
	logic [2:0]       spd_a;
	logic [2:0]       spd_b;
	dsps_pkg::motor_t mot_a_d;
	dsps_pkg::motor_t mot_b_d;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_comb begin
		if (test_s1) begin
			en_a  = 1'b1;
			en_b  = 1'b1;
			up_a  = 1'b1;
			up_b  = 1'b0;
			spd_a = dsps_pkg::TEST_SPEED;
			spd_b = dsps_pkg::TEST_SPEED;
		end else begin
			en_a  = cmd_s1[2];
			en_b  = cmd_s1[3];
			up_a  = cmd_s1[4];
			up_b  = cmd_s1[5];
			spd_a = cmd_s1[8:6];
			spd_b = cmd_s1[11:9];
		end
	end

	always_comb begin
		mot_a_d = mot_a_q;
		mot_b_d = mot_b_q;
		if (tick_q) begin
			if (en_a) mot_a_d = dsps_pkg::motor_step(mot_a_q, spd_a, up_a);
			if (en_b) mot_b_d = dsps_pkg::motor_step(mot_b_q, spd_b, up_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			tick_q      <= 1'b0;
			mot_a_q     <= '0;
			mot_b_q     <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				tick_q      <= !tick_q;
				mot_a_q     <= mot_a_d;
				mot_b_q     <= mot_b_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= command_word;
			test_s1 <= test_mode;
		end
		if (advance) begin
			coil_a_q <= en_a ? dsps_pkg::coil_of(mot_a_d.phase) : 4'd0;
			coil_b_q <= en_b ? dsps_pkg::coil_of(mot_b_d.phase) : 4'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign coil_a    = coil_a_q;
	assign coil_b    = coil_b_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stall without a held item");

	a_tick_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> tick_q != $past(tick_q))
		else $error("tick phase did not toggle on a transaction");

	a_disabled_a_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !en_a) |=> $stable(mot_a_q))
		else $error("disabled motor one state changed");

	a_coil_a_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && coil_a != 4'd0) |-> (coil_a == dsps_pkg::COIL_P0 ||
		coil_a == dsps_pkg::COIL_P1 || coil_a == dsps_pkg::COIL_P2 ||
		coil_a == dsps_pkg::COIL_P3))
		else $error("motor one coil pattern not in phase table");
`endif

endmodule

`default_nettype wire

### tb/tb_dual_stepper_phase_sequencer_core.sv
// tb_dual_stepper_phase_sequencer_core: self-checking testbench for the dual stepper
// phase sequencer; predicts both coil patterns per control pass and checks every result
// depends on dual_stepper_phase_sequencer_core and dsps_pkg
`default_nettype none

module tb_dual_stepper_phase_sequencer_core;

	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		logic [2:0] held_speed;
		logic [2:0] countdown;
		logic [1:0] phase;
	} stepper_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
	} coil_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] command_word = 12'd0;
	logic        test_mode = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  coil_a;
	logic [3:0]  coil_b;

	logic       tick_q = 1'b0;
	stepper_t   motor_a_q = '0;
	stepper_t   motor_b_q = '0;
	coil_pair_t coil_expect_q[$];

	int  errors = 0;
	int  passes_sent = 0;
	int  results_checked = 0;
	int  steps_predicted = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	bit  hold_toggle = 1'b0;
	bit  hold_seen = 1'b0;

	dual_stepper_phase_sequencer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command_word (command_word),
		.test_mode    (test_mode),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coil_a       (coil_a),
		.coil_b       (coil_b)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
		logic [3:0] table_q [4];
		table_q = '{dsps_pkg::COIL_P0, dsps_pkg::COIL_P1,
			dsps_pkg::COIL_P2, dsps_pkg::COIL_P3};
		return table_q[ph];
	endfunction

	function automatic stepper_t advance_motor(input stepper_t m, input logic [2:0] speed,
		input logic up);
		stepper_t n;
		n = m;
		if (m.held_speed != speed) begin
			n.held_speed = speed;
			n.countdown  = speed;
		end else if (m.countdown != 3'd0) begin
			n.countdown = m.countdown - 3'd1;
		end else begin
			n.countdown = m.held_speed;
			n.phase     = up ? m.phase + 2'd1 : m.phase + 2'd3;
			steps_predicted++;
		end
		return n;
	endfunction

	function automatic coil_pair_t predict_coils(input logic [11:0] cmd, input logic tm);
		logic       en_a, en_b, up_a, up_b;
		logic [2:0] spd_a, spd_b;
		coil_pair_t c;
		if (tm) begin
			en_a  = 1'b1;
			en_b  = 1'b1;
			up_a  = 1'b1;
			up_b  = 1'b0;
			spd_a = dsps_pkg::TEST_SPEED;
			spd_b = dsps_pkg::TEST_SPEED;
		end else begin
			en_a  = cmd[2];
			en_b  = cmd[3];
			up_a  = cmd[4];
			up_b  = cmd[5];
			spd_a = cmd[8:6];
			spd_b = cmd[11:9];
		end
		if (!tick_q) begin
			tick_q = 1'b1;
		end else begin
			if (en_a) motor_a_q = advance_motor(motor_a_q, spd_a, up_a);
			if (en_b) motor_b_q = advance_motor(motor_b_q, spd_b, up_b);
			tick_q = 1'b0;
		end
		c.a = en_a ? coil_pattern(motor_a_q.phase) : 4'd0;
		c.b = en_b ? coil_pattern(motor_b_q.phase) : 4'd0;
		return c;
	endfunction

	task automatic send_pass(input logic [11:0] cmd, input logic tm);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command_word <= cmd;
		test_mode    <= tm;
		coil_expect_q.push_back(predict_coils(cmd, tm));
		passes_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [11:0] make_cmd(input logic [2:0] spd_b, input logic [2:0] spd_a,
		input logic dir_b, input logic dir_a, input logic en_b, input logic en_a);
		return {spd_b, spd_a, dir_b, dir_a, en_b, en_a, 2'($urandom_range(3))};
	endfunction

	task automatic test_both_disabled();
		send_pass(12'h000, 1'b0);
		send_pass(12'h003, 1'b0);
		send_pass(12'hFF3, 1'b0);
	endtask

	task automatic test_all_ones();
		repeat (4) send_pass(12'hFFF, 1'b0);
	endtask

	task automatic test_forced_drive();
		send_pass(12'h000, 1'b1);
		send_pass(12'hFFF, 1'b1);
		send_pass(12'h000, 1'b1);
		send_pass(12'h5A5, 1'b1);
	endtask

	task automatic test_speed_zero();
		repeat (4) send_pass(make_cmd(3'd0, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
	endtask

	task automatic test_one_motor_disabled();
		repeat (3) send_pass(make_cmd(3'd0, 3'd0, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
		repeat (3) send_pass(make_cmd(3'd0, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0), 1'b0);
	endtask

	task automatic test_direction_down();
		repeat (4) send_pass(make_cmd(3'd0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
	endtask

	task automatic test_random_motion(input int n);
		logic [2:0] spd_a, spd_b;
		logic       dir_a, dir_b, en_a, en_b;
		int         run_left;
		int         r;
		run_left = 0;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(60, 4);
				spd_a = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
				spd_b = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
				dir_a = 1'($urandom_range(1));
				dir_b = 1'($urandom_range(1));
				en_a  = ($urandom_range(9) != 0);
				en_b  = ($urandom_range(9) != 0);
			end
			run_left--;
			r = $urandom_range(99);
			if (r < 6)
				send_pass(12'($urandom_range(4095)), 1'($urandom_range(1)));
			else if (r < 10)
				send_pass(12'($urandom_range(4095)), 1'b1);
			else if (r < 16)
				send_pass(make_cmd(spd_b, spd_a, dir_b, dir_a,
					1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0);
			else
				send_pass(make_cmd(spd_b, spd_a, dir_b, dir_a, en_b, en_a), 1'b0);
		end
	endtask

	task automatic test_output_backpressure();
		hold_toggle <= ~hold_toggle;
		for (int i = 0; i < 30; i++)
			send_pass(make_cmd(3'd1, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
	endtask

	always @(posedge clk) begin : result_check
		coil_pair_t exp_c;
		if (out_valid && !out_stall) begin
			if (coil_expect_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t unexpected result: coil_a %h coil_b %h", $time, coil_a, coil_b);
			end else begin
				exp_c = coil_expect_q.pop_front();
				results_checked++;
				if (coil_a !== exp_c.a) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t coil_a mismatch: expected %h actual %h",
							$time, exp_c.a, coil_a);
				end
				if (coil_b !== exp_c.b) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t coil_b mismatch: expected %h actual %h",
							$time, exp_c.b, coil_b);
				end
			end
		end
		if (hold_seen != hold_toggle) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("dual_stepper_phase_sequencer_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_both_disabled();
		test_all_ones();
		test_forced_drive();
		test_speed_zero();
		test_one_motor_disabled();
		test_direction_down();

		send_idle_pct = 36;
		recv_idle_pct = 80;
		test_random_motion(520);
		send_idle_pct = 80;
		recv_idle_pct = 36;
		test_random_motion(500);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_motion(500);
		test_output_backpressure();
		go_idle();

		while (coil_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d control passes, checked %0d coil results, %0d predicted steps",
			passes_sent, results_checked, steps_predicted);
		$display("covered forced drive, disabled motors, speed changes and output hold-off");
		if (errors == 0)
			$display("dual_stepper_phase_sequencer_core test passed");
		else
			$display("dual_stepper_phase_sequencer_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/core/dsps_pkg.sv
rtl/core/dual_stepper_phase_sequencer_core.sv
tb/tb_dual_stepper_phase_sequencer_core.sv
